[rtl/dagcc_pkg.sv]
package dagcc_pkg;

	localparam int DEF_MAX_NODES   = 32;
	localparam int DEF_MAX_EDGES   = 64;
	localparam int DEF_MAX_OUT_DEG = 8;
	localparam int DEF_MAX_IN_DEG  = 8;

	localparam int NODE_W   = 5;
	localparam int NCOUNT_W = 6;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 6;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_BAD_NODE   = 3'd1,
		ST_EDGES_FULL = 3'd2,
		ST_OUT_FULL   = 3'd3,
		ST_IN_FULL    = 3'd4
	} dagcc_status_t;

	typedef struct packed {
		logic [NODE_W-1:0] producer_node;
		logic [NODE_W-1:0] consumer_node;
		logic              last_edge;
	} dagcc_edge_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   edge_slot;
		logic                check_done;
		logic                is_acyclic;
	} dagcc_result_t;

	typedef struct packed {
		logic wr;
		logic clear;
	} dagcc_store_ctl_t;

	typedef struct packed {
		logic push;
		logic mark;
		logic unmark;
		logic clear;
	} dagcc_walk_ctl_t;

endpackage

[rtl/dagcc_graph_store.sv]
module dagcc_graph_store #(
	parameter int MAX_NODES   = dagcc_pkg::DEF_MAX_NODES,
	parameter int MAX_OUT_DEG = dagcc_pkg::DEF_MAX_OUT_DEG,
	parameter int MAX_IN_DEG  = dagcc_pkg::DEF_MAX_IN_DEG
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  dagcc_pkg::dagcc_store_ctl_t                  ctl,
	input  logic [$clog2(MAX_NODES)-1:0]                 od_raddr,
	input  logic [$clog2(MAX_NODES)-1:0]                 id_raddr,
	input  logic [$clog2(MAX_NODES*MAX_OUT_DEG)-1:0]     succ_raddr,
	input  logic [$clog2(MAX_NODES)-1:0]                 wr_producer,
	input  logic [$clog2(MAX_NODES)-1:0]                 wr_consumer,
	input  logic [$clog2(MAX_NODES*MAX_OUT_DEG)-1:0]     succ_waddr,
	input  logic [$clog2(MAX_OUT_DEG)-1:0]               od_wdata,
	input  logic [$clog2(MAX_IN_DEG)-1:0]                id_wdata,
	output logic [$clog2(MAX_OUT_DEG)-1:0]               od_rdata,
	output logic [$clog2(MAX_IN_DEG)-1:0]                id_rdata,
	output logic [$clog2(MAX_NODES)-1:0]                 succ_rdata
);
	import dagcc_pkg::*;

	localparam int NW    = $clog2(MAX_NODES);
	localparam int ODW   = $clog2(MAX_OUT_DEG);
	localparam int IDW   = $clog2(MAX_IN_DEG);
	localparam int SDEPTH = MAX_NODES * MAX_OUT_DEG;

	logic [NW-1:0]  succ_mem [SDEPTH];
	logic [ODW-1:0] od_mem [MAX_NODES];
	logic [IDW-1:0] id_mem [MAX_NODES];

	logic [MAX_NODES-1:0] od_valid_q;
	logic [MAX_NODES-1:0] id_valid_q;

	logic [NW-1:0]  succ_rd_q;
	logic [ODW-1:0] od_rd_q;
	logic [IDW-1:0] id_rd_q;
	logic           od_vld_q;
	logic           id_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			succ_mem[succ_waddr] <= wr_consumer;
			od_mem[wr_producer]  <= od_wdata;
			id_mem[wr_consumer]  <= id_wdata;
		end
		succ_rd_q <= succ_mem[succ_raddr];
		od_rd_q   <= od_mem[od_raddr];
		id_rd_q   <= id_mem[id_raddr];
		od_vld_q  <= od_valid_q[od_raddr];
		id_vld_q  <= id_valid_q[id_raddr];
	end

	// A count whose valid bit is clear reads as zero, so a new graph starts empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			od_valid_q <= '0;
			id_valid_q <= '0;
		end else if (ctl.clear) begin
			od_valid_q <= '0;
			id_valid_q <= '0;
		end else if (ctl.wr) begin
			od_valid_q[wr_producer] <= 1'b1;
			id_valid_q[wr_consumer] <= 1'b1;
		end
	end

	assign od_rdata   = od_vld_q ? od_rd_q : '0;
	assign id_rdata   = id_vld_q ? id_rd_q : '0;
	assign succ_rdata = succ_rd_q;

endmodule

[rtl/dagcc_walk_mem.sv]
module dagcc_walk_mem #(
	parameter int MAX_NODES   = dagcc_pkg::DEF_MAX_NODES,
	parameter int MAX_OUT_DEG = dagcc_pkg::DEF_MAX_OUT_DEG
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dagcc_pkg::dagcc_walk_ctl_t       ctl,
	input  logic [$clog2(MAX_NODES)-1:0]     stk_addr,
	input  logic [$clog2(MAX_NODES)-1:0]     stk_wnode,
	input  logic [$clog2(MAX_OUT_DEG)-1:0]   stk_wcur,
	input  logic [$clog2(MAX_NODES)-1:0]     mark_idx,
	input  logic [$clog2(MAX_NODES)-1:0]     unmark_idx,
	output logic [$clog2(MAX_NODES)-1:0]     stk_rnode,
	output logic [$clog2(MAX_OUT_DEG)-1:0]   stk_rcur,
	output logic [MAX_NODES-1:0]             visited,
	output logic [MAX_NODES-1:0]             on_path
);
	import dagcc_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_OUT_DEG);

	logic [NW-1:0] stk_node_mem [MAX_NODES];
	logic [CW-1:0] stk_cur_mem [MAX_NODES];

	logic [NW-1:0]        stk_node_q;
	logic [CW-1:0]        stk_cur_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [MAX_NODES-1:0] on_path_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			stk_node_mem[stk_addr] <= stk_wnode;
			stk_cur_mem[stk_addr]  <= stk_wcur;
		end
		stk_node_q <= stk_node_mem[stk_addr];
		stk_cur_q  <= stk_cur_mem[stk_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			on_path_q <= '0;
		end else if (ctl.clear) begin
			visited_q <= '0;
			on_path_q <= '0;
		end else begin
			if (ctl.mark) begin
				visited_q[mark_idx] <= 1'b1;
				on_path_q[mark_idx] <= 1'b1;
			end
			if (ctl.unmark) begin
				on_path_q[unmark_idx] <= 1'b0;
			end
		end
	end

	assign stk_rnode = stk_node_q;
	assign stk_rcur  = stk_cur_q;
	assign visited   = visited_q;
	assign on_path   = on_path_q;

endmodule

[rtl/dag_edge_loader_cycle_check_core.sv]
// Port group   Direction  Handshake          Payload
// edge words   in         start, busy        edge_data (producer, consumer, last mark)
// result words out        result_valid       result (status, slot, verdict)
// config       in         cfg_we             cfg_wdata (node count)
//
// An edge is taken on a cycle with start high and busy low, checked and stored in the
// next cycle, and its result word shows in the cycle after that, so a new edge is taken
// only once the last one is checked. A last edge adds the depth-first walk, which moves
// the node stack one step at a time through the count and successor memories.
// Reset clears the node count, the edge total, the count valid bits and all marks.
// The receiver cannot stall; each result word is valid for exactly one cycle.
module dag_edge_loader_cycle_check_core #(
	parameter int MAX_NODES   = dagcc_pkg::DEF_MAX_NODES,
	parameter int MAX_EDGES   = dagcc_pkg::DEF_MAX_EDGES,
	parameter int MAX_OUT_DEG = dagcc_pkg::DEF_MAX_OUT_DEG,
	parameter int MAX_IN_DEG  = dagcc_pkg::DEF_MAX_IN_DEG
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  dagcc_pkg::dagcc_edge_t                 edge_data,
	output logic                                   result_valid,
	output dagcc_pkg::dagcc_result_t               result,
	input  logic                                   cfg_we,
	input  logic [dagcc_pkg::NCOUNT_W-1:0]         cfg_wdata
);
	import dagcc_pkg::*;

	localparam int NW  = $clog2(MAX_NODES);
	localparam int NCW = $clog2(MAX_NODES + 1);
	localparam int ETW = $clog2(MAX_EDGES);
	localparam int ODW = $clog2(MAX_OUT_DEG);
	localparam int IDW = $clog2(MAX_IN_DEG);
	localparam int SAW = $clog2(MAX_NODES * MAX_OUT_DEG);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_LCHK  = 8'b0000_0010,
		S_ROOT  = 8'b0000_0100,
		S_DEGRD = 8'b0000_1000,
		S_EXAM  = 8'b0001_0000,
		S_SUCC  = 8'b0010_0000,
		S_POPRD = 8'b0100_0000,
		S_POPLD = 8'b1000_0000
	} dagcc_state_t;

	dagcc_state_t        state_q;
	logic [NCOUNT_W-1:0] node_count_q;
	logic [ETW-1:0]      edge_total_q;
	logic [NCW-1:0]      root_q;
	logic [NCW-1:0]      depth_q;
	logic                result_valid_q;

	dagcc_edge_t         edge_q;
	dagcc_result_t       result_q;
	logic [STATUS_W-1:0] save_status_q;
	logic [SLOT_W-1:0]   save_slot_q;
	logic [NW-1:0]       v_q;
	logic [ODW-1:0]      c_q;

	dagcc_store_ctl_t    store_ctl;
	dagcc_walk_ctl_t     walk_ctl;

	logic [NCW-1:0]      n_act;
	logic [NW-1:0]       p_idx;
	logic [NW-1:0]       c_idx;
	logic [NW-1:0]       root_idx;
	logic [ODW-1:0]      od_rdata;
	logic [IDW-1:0]      id_rdata;
	logic [NW-1:0]       s_idx;
	logic [NW-1:0]       stk_rnode;
	logic [ODW-1:0]      stk_rcur;
	logic [MAX_NODES-1:0] visited;
	logic [MAX_NODES-1:0] on_path;
	logic [NW-1:0]       od_raddr;
	logic [NW-1:0]       stk_addr;
	logic [SAW-1:0]      succ_raddr;
	logic [SAW-1:0]      succ_waddr;

	dagcc_status_t       chk_status;
	logic                accept_edge;
	logic                root_done;
	logic                has_next;
	logic                found_cycle;
	logic                push_ok;
	logic                walk_end;

	always_comb begin
		if (int'(node_count_q) > MAX_NODES) begin
			n_act = NCW'(MAX_NODES);
		end else begin
			n_act = NCW'(node_count_q);
		end
	end

	assign p_idx    = NW'(edge_q.producer_node);
	assign c_idx    = NW'(edge_q.consumer_node);
	assign root_idx = NW'(root_q);

	// Checks in priority order; a full count sits at one below its limit.
	always_comb begin
		if (int'(edge_q.producer_node) >= int'(n_act) ||
				int'(edge_q.consumer_node) >= int'(n_act)) begin
			chk_status = ST_BAD_NODE;
		end else if (edge_total_q == ETW'(MAX_EDGES - 1)) begin
			chk_status = ST_EDGES_FULL;
		end else if (od_rdata == ODW'(MAX_OUT_DEG - 1)) begin
			chk_status = ST_OUT_FULL;
		end else if (id_rdata == IDW'(MAX_IN_DEG - 1)) begin
			chk_status = ST_IN_FULL;
		end else begin
			chk_status = ST_OK;
		end
	end

	assign accept_edge = (state_q == S_LCHK) && (chk_status == ST_OK);
	assign root_done   = root_q >= n_act;
	assign has_next    = c_q < od_rdata;
	assign found_cycle = on_path[s_idx];
	assign push_ok     = !visited[s_idx] && (int'(depth_q) < MAX_NODES);
	assign walk_end    = ((state_q == S_ROOT) && root_done) ||
		((state_q == S_SUCC) && found_cycle);

	// During a load the count read follows the incoming word; during the walk, the top node.
	assign od_raddr   = (state_q == S_IDLE) ? NW'(edge_data.producer_node) : v_q;
	assign succ_raddr = SAW'(int'(v_q) * MAX_OUT_DEG + int'(c_q));
	assign succ_waddr = SAW'(int'(p_idx) * MAX_OUT_DEG + int'(od_rdata));
	assign stk_addr   = NW'(depth_q - NCW'(1));

	always_comb begin
		store_ctl.wr    = accept_edge;
		store_ctl.clear = walk_end;

		walk_ctl.push   = (state_q == S_SUCC) && !found_cycle && push_ok;
		walk_ctl.mark   = ((state_q == S_ROOT) && !root_done && !visited[root_idx]) ||
			walk_ctl.push;
		walk_ctl.unmark = (state_q == S_EXAM) && !has_next;
		walk_ctl.clear  = walk_end;
	end

	dagcc_graph_store #(
		.MAX_NODES   (MAX_NODES),
		.MAX_OUT_DEG (MAX_OUT_DEG),
		.MAX_IN_DEG  (MAX_IN_DEG)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (store_ctl),
		.od_raddr    (od_raddr),
		.id_raddr    (NW'(edge_data.consumer_node)),
		.succ_raddr  (succ_raddr),
		.wr_producer (p_idx),
		.wr_consumer (c_idx),
		.succ_waddr  (succ_waddr),
		.od_wdata    (od_rdata + ODW'(1)),
		.id_wdata    (id_rdata + IDW'(1)),
		.od_rdata    (od_rdata),
		.id_rdata    (id_rdata),
		.succ_rdata  (s_idx)
	);

	dagcc_walk_mem #(
		.MAX_NODES   (MAX_NODES),
		.MAX_OUT_DEG (MAX_OUT_DEG)
	) u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (walk_ctl),
		.stk_addr   (stk_addr),
		.stk_wnode  (v_q),
		.stk_wcur   (c_q),
		.mark_idx   ((state_q == S_ROOT) ? root_idx : s_idx),
		.unmark_idx (v_q),
		.stk_rnode  (stk_rnode),
		.stk_rcur   (stk_rcur),
		.visited    (visited),
		.on_path    (on_path)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			node_count_q   <= '0;
			edge_total_q   <= '0;
			root_q         <= '0;
			depth_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_LCHK;
					end
				end
				S_LCHK: begin
					if (accept_edge) begin
						edge_total_q <= edge_total_q + ETW'(1);
					end
					if (edge_q.last_edge) begin
						root_q  <= '0;
						depth_q <= '0;
						state_q <= S_ROOT;
					end else begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				S_ROOT: begin
					if (root_done) begin
						result_valid_q <= 1'b1;
						edge_total_q   <= '0;
						state_q        <= S_IDLE;
					end else if (visited[root_idx]) begin
						root_q <= root_q + NCW'(1);
					end else begin
						depth_q <= NCW'(1);
						state_q <= S_DEGRD;
					end
				end
				S_DEGRD: begin
					state_q <= S_EXAM;
				end
				S_EXAM: begin
					if (has_next) begin
						state_q <= S_SUCC;
					end else if (depth_q == NCW'(1)) begin
						depth_q <= '0;
						root_q  <= root_q + NCW'(1);
						state_q <= S_ROOT;
					end else begin
						depth_q <= depth_q - NCW'(1);
						state_q <= S_POPRD;
					end
				end
				S_SUCC: begin
					if (found_cycle) begin
						result_valid_q <= 1'b1;
						edge_total_q   <= '0;
						depth_q        <= '0;
						state_q        <= S_IDLE;
					end else if (push_ok) begin
						depth_q <= depth_q + NCW'(1);
						state_q <= S_DEGRD;
					end else begin
						state_q <= S_EXAM;
					end
				end
				S_POPRD: begin
					state_q <= S_POPLD;
				end
				S_POPLD: begin
					state_q <= S_DEGRD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					edge_q <= edge_data;
				end
			end
			S_LCHK: begin
				save_status_q       <= chk_status;
				save_slot_q         <= accept_edge ? SLOT_W'(edge_total_q) : '0;
				result_q.status     <= chk_status;
				result_q.edge_slot  <= accept_edge ? SLOT_W'(edge_total_q) : '0;
				result_q.check_done <= 1'b0;
				result_q.is_acyclic <= 1'b0;
			end
			S_ROOT: begin
				if (root_done) begin
					result_q.status     <= save_status_q;
					result_q.edge_slot  <= save_slot_q;
					result_q.check_done <= 1'b1;
					result_q.is_acyclic <= 1'b1;
				end else if (!visited[root_idx]) begin
					v_q <= root_idx;
					c_q <= '0;
				end
			end
			S_EXAM: begin
				if (has_next) begin
					c_q <= c_q + ODW'(1);
				end
			end
			S_SUCC: begin
				if (found_cycle) begin
					result_q.status     <= save_status_q;
					result_q.edge_slot  <= save_slot_q;
					result_q.check_done <= 1'b1;
					result_q.is_acyclic <= 1'b0;
				end else if (push_ok) begin
					v_q <= s_idx;
					c_q <= '0;
				end
			end
			S_POPLD: begin
				v_q <= stk_rnode;
				c_q <= stk_rcur;
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The result word arrives exactly as the block becomes free again.
	a_result_on_free: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid)
		else $error("busy dropped without a result word");

	a_slot_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status != ST_OK) |-> result.edge_slot == '0)
		else $error("rejected edge reported a slot");

	a_stack_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> depth_q == '0)
		else $error("walk stack not empty while idle");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(depth_q) <= MAX_NODES)
		else $error("walk stack deeper than node capacity");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import dagcc_pkg::*;

	localparam int MAX_NODES    = DEF_MAX_NODES;
	localparam int MAX_EDGES    = DEF_MAX_EDGES;
	localparam int MAX_OUT_DEG  = DEF_MAX_OUT_DEG;
	localparam int MAX_IN_DEG   = DEF_MAX_IN_DEG;
	localparam int ITEM_TARGET  = 1150;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 400;

	typedef enum {ROW_CFG, ROW_EDGE} row_kind_t;
	typedef enum {
		SHAPE_DAG, SHAPE_ANY, SHAPE_FANOUT, SHAPE_FANIN, SHAPE_RING, SHAPE_FILL
	} shape_t;

	typedef struct {
		row_kind_t     kind;
		int            cfg_val;
		dagcc_edge_t   word;
		bit            fixed;
		dagcc_result_t fixed_res;
	} stim_row_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	dagcc_edge_t   edge_data;
	logic          result_valid;
	dagcc_result_t result;
	logic          cfg_we;
	logic [NCOUNT_W-1:0] cfg_wdata;

	dag_edge_loader_cycle_check_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.edge_data    (edge_data),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Shadow of the graph store.
	int node_count_reg;
	int succ_tab [MAX_NODES][MAX_OUT_DEG];
	int fanout_cnt [MAX_NODES];
	int fanin_cnt [MAX_NODES];
	int stored_edges;
	bit seen [MAX_NODES];
	bit on_stack [MAX_NODES];
	int stk_node [MAX_NODES];
	int stk_pos [MAX_NODES];

	dagcc_result_t pending_results[$];
	stim_row_t     directed_rows[$];

	int burst_left;
	int items_sent;
	int cfg_writes;
	int errors;
	int idle_cycles;
	int status_seen [8];
	int acyclic_seen;
	int cyclic_seen;

	function automatic int live_nodes();
		return (node_count_reg > MAX_NODES) ? MAX_NODES : node_count_reg;
	endfunction

	function automatic void clear_graph();
		for (int i = 0; i < MAX_NODES; i++) begin
			fanout_cnt[i] = 0;
			fanin_cnt[i]  = 0;
		end
		stored_edges = 0;
	endfunction

	// Depth-first walk over the stored edges, from roots taken in index order below the
	// current node count. Reaching a node still on the path means a cycle.
	function automatic bit graph_is_acyclic();
		int lim;
		int depth;
		int v;
		int k;
		int s;
		lim = live_nodes();
		for (int i = 0; i < MAX_NODES; i++) begin
			seen[i]     = 1'b0;
			on_stack[i] = 1'b0;
		end
		for (int root = 0; root < lim; root++) begin
			if (seen[root])
				continue;
			seen[root]     = 1'b1;
			on_stack[root] = 1'b1;
			stk_node[0]    = root;
			stk_pos[0]     = 0;
			depth          = 1;
			while (depth > 0) begin
				v = stk_node[depth-1] % MAX_NODES;
				k = stk_pos[depth-1];
				if (k < fanout_cnt[v] && k < MAX_OUT_DEG) begin
					s = succ_tab[v][k] % MAX_NODES;
					stk_pos[depth-1] = k + 1;
					if (on_stack[s])
						return 1'b0;
					if (!seen[s] && depth < MAX_NODES) begin
						seen[s]         = 1'b1;
						on_stack[s]     = 1'b1;
						stk_node[depth] = s;
						stk_pos[depth]  = 0;
						depth++;
					end
				end else begin
					on_stack[v] = 1'b0;
					depth--;
				end
			end
		end
		return 1'b1;
	endfunction

	function automatic dagcc_result_t predict_edge_result(dagcc_edge_t w);
		dagcc_result_t r;
		int p;
		int c;
		int lim;
		r   = '0;
		p   = w.producer_node;
		c   = w.consumer_node;
		lim = live_nodes();
		if (p >= lim || c >= lim)
			r.status = ST_BAD_NODE;
		else if (stored_edges + 1 >= MAX_EDGES)
			r.status = ST_EDGES_FULL;
		else if (fanout_cnt[p] + 1 >= MAX_OUT_DEG)
			r.status = ST_OUT_FULL;
		else if (fanin_cnt[c] + 1 >= MAX_IN_DEG)
			r.status = ST_IN_FULL;
		else begin
			r.status    = ST_OK;
			r.edge_slot = SLOT_W'(stored_edges);
			succ_tab[p][fanout_cnt[p]] = c;
			fanout_cnt[p]++;
			fanin_cnt[c]++;
			stored_edges++;
		end
		if (w.last_edge) begin
			r.check_done = 1'b1;
			r.is_acyclic = graph_is_acyclic();
			clear_graph();
		end
		return r;
	endfunction

	function automatic void add_cfg_row(int v);
		stim_row_t row;
		row.kind      = ROW_CFG;
		row.cfg_val   = v;
		row.word      = '0;
		row.fixed     = 1'b0;
		row.fixed_res = '0;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_edge_row(int p, int c, bit last, bit fixed = 1'b0,
			dagcc_status_t st = ST_OK, int slot = 0, bit done = 1'b0, bit acy = 1'b0);
		stim_row_t row;
		row.kind                 = ROW_EDGE;
		row.cfg_val              = 0;
		row.word.producer_node   = NODE_W'(p);
		row.word.consumer_node   = NODE_W'(c);
		row.word.last_edge       = last;
		row.fixed                = fixed;
		row.fixed_res.status     = st;
		row.fixed_res.edge_slot  = SLOT_W'(slot);
		row.fixed_res.check_done = done;
		row.fixed_res.is_acyclic = acy;
		directed_rows.push_back(row);
	endfunction

	function automatic int pick_node_count();
		int r;
		r = $urandom_range(0, 19);
		case (r)
			0: return 0;
			1: return 1;
			2: return 2;
			3: return 32;
			4: return $urandom_range(33, 63);
			5: return 63;
			default: return $urandom_range(3, 32);
		endcase
	endfunction

	function automatic int pick_node(int n_act);
		return (n_act == 0) ? $urandom_range(0, 31) : $urandom_range(0, n_act - 1);
	endfunction

	// Start stays high from one accepted word to the next within a burst.
	task automatic send_edge(input dagcc_edge_t w, input bit fixed,
			input dagcc_result_t fixed_res);
		dagcc_result_t r;
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		start     <= 1'b1;
		edge_data <= w;
		do @(posedge clk); while (busy);
		r = predict_edge_result(w);
		pending_results.push_back(fixed ? fixed_res : r);
		burst_left--;
		items_sent++;
	endtask

	task automatic write_node_count(input int v);
		start <= 1'b0;
		while (pending_results.size() != 0 || busy) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= NCOUNT_W'(v);
		@(posedge clk);
		node_count_reg = v & 63;
		cfg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random_graph();
		shape_t      shape;
		dagcc_edge_t w;
		int          len;
		int          n_act;
		int          hub;
		int          base;
		int          p;
		int          c;
		if ($urandom_range(0, 2) == 0)
			write_node_count(pick_node_count());
		shape = ($urandom_range(0, 15) == 0) ? SHAPE_FILL : shape_t'($urandom_range(0, 4));
		if (shape == SHAPE_FILL && live_nodes() < 16)
			write_node_count(32);
		n_act = live_nodes();
		case (shape)
			SHAPE_DAG:    len = $urandom_range(1, 24);
			SHAPE_ANY:    len = $urandom_range(1, 16);
			SHAPE_FANOUT: len = $urandom_range(6, 11);
			SHAPE_FANIN:  len = $urandom_range(6, 11);
			SHAPE_RING:   len = $urandom_range(2, 12);
			default:      len = $urandom_range(62, 70);
		endcase
		hub  = pick_node(n_act);
		base = pick_node(n_act);
		for (int i = 0; i < len; i++) begin
			// Now and then the node count moves while a graph is half loaded.
			if (i == len / 2 && i > 0 && $urandom_range(0, 14) == 0) begin
				write_node_count(pick_node_count());
				n_act = live_nodes();
			end
			p = pick_node(n_act);
			c = pick_node(n_act);
			case (shape)
				SHAPE_DAG: begin
					if (n_act >= 2) begin
						p = $urandom_range(0, n_act - 2);
						c = $urandom_range(p + 1, n_act - 1);
					end
				end
				SHAPE_FANOUT: p = hub;
				SHAPE_FANIN:  c = hub;
				SHAPE_RING: begin
					if (n_act > 0) begin
						p = (base + i) % n_act;
						c = (i == len - 1 && $urandom_range(0, 1) == 0) ? base
							: (base + i + 1) % n_act;
					end
				end
				SHAPE_FILL: begin
					if (n_act > 0) begin
						p = i % n_act;
						if ($urandom_range(0, 1) == 0)
							c = (p + 1 + i / n_act) % n_act;
					end
				end
				default: ;
			endcase
			if ($urandom_range(0, 11) == 0) begin
				p = $urandom_range(0, 31);
				c = $urandom_range(0, 31);
			end
			w.producer_node = NODE_W'(p);
			w.consumer_node = NODE_W'(c);
			w.last_edge     = (i == len - 1) || ($urandom_range(0, 39) == 0);
			send_edge(w, 1'b0, '0);
		end
	endtask

	// Result words cannot be held off, so every valid cycle is checked.
	always @(posedge clk) begin
		dagcc_result_t want;
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((start && !busy) || result_valid)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (result_valid) begin
				status_seen[result.status]++;
				if (result.check_done) begin
					if (result.is_acyclic)
						acyclic_seen++;
					else
						cyclic_seen++;
				end
				if (pending_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: status=%0d slot=%0d done=%0b acyclic=%0b",
							result.status, result.edge_slot, result.check_done, result.is_acyclic);
				end else begin
					want = pending_results.pop_front();
					if (result.status !== want.status || result.edge_slot !== want.edge_slot ||
							result.check_done !== want.check_done ||
							result.is_acyclic !== want.is_acyclic) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch: expected status=%0d slot=%0d done=%0b acyclic=%0b",
								want.status, want.edge_slot, want.check_done, want.is_acyclic);
							$display("          got      status=%0d slot=%0d done=%0b acyclic=%0b",
								result.status, result.edge_slot, result.check_done,
								result.is_acyclic);
						end
					end
				end
			end
		end
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("[dag_edge_loader_cycle_check_core] ERROR");
		$finish;
	end

	initial begin
		stim_row_t row;
		arst_n         = 1'b0;
		start          = 1'b0;
		edge_data      = '0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		node_count_reg = 0;
		burst_left     = 0;
		items_sent     = 0;
		cfg_writes     = 0;
		errors         = 0;
		idle_cycles    = 0;
		acyclic_seen   = 0;
		cyclic_seen    = 0;
		for (int i = 0; i < 8; i++)
			status_seen[i] = 0;
		clear_graph();

		// With no nodes every edge is bad, and the walk finds nothing.
		add_cfg_row(0);
		add_edge_row(0, 0, 1'b0, 1'b1, ST_BAD_NODE, 0, 1'b0, 1'b0);
		add_edge_row(31, 31, 1'b1, 1'b1, ST_BAD_NODE, 0, 1'b1, 1'b1);
		// A count above the node limit acts as the limit.
		add_cfg_row(63);
		add_edge_row(31, 0, 1'b0, 1'b1, ST_OK, 0, 1'b0, 1'b0);
		add_edge_row(0, 31, 1'b0, 1'b1, ST_OK, 1, 1'b0, 1'b0);
		add_edge_row(31, 31, 1'b1, 1'b1, ST_OK, 2, 1'b1, 1'b0);
		add_cfg_row(32);
		add_edge_row(5, 5, 1'b1, 1'b1, ST_OK, 0, 1'b1, 1'b0);
		add_cfg_row(1);
		add_edge_row(0, 0, 1'b1, 1'b1, ST_OK, 0, 1'b1, 1'b0);
		add_edge_row(0, 1, 1'b0, 1'b1, ST_BAD_NODE, 0, 1'b0, 1'b0);
		// A rejected last edge still runs the walk on what is stored.
		add_edge_row(1, 0, 1'b1, 1'b1, ST_BAD_NODE, 0, 1'b1, 1'b1);
		add_cfg_row(2);
		add_edge_row(0, 1, 1'b0, 1'b1, ST_OK, 0, 1'b0, 1'b0);
		add_edge_row(1, 0, 1'b1, 1'b1, ST_OK, 1, 1'b1, 1'b0);
		add_cfg_row(20);
		add_edge_row(0, 1, 1'b0);
		add_edge_row(1, 2, 1'b0);
		add_edge_row(2, 3, 1'b1);
		// The cycle between 10 and 11 is kept but no root reaches it after the count drops.
		add_edge_row(10, 11, 1'b0);
		add_edge_row(11, 10, 1'b0);
		add_cfg_row(3);
		add_edge_row(0, 1, 1'b1);
		add_cfg_row(32);
		add_edge_row(31, 0, 1'b1, 1'b1, ST_OK, 0, 1'b1, 1'b1);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_CFG)
				write_node_count(row.cfg_val);
			else
				send_edge(row.word, row.fixed, row.fixed_res);
		end
		while (items_sent < ITEM_TARGET)
			run_random_graph();

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Loaded %0d edge words, %0d graph checks (%0d acyclic, %0d cyclic).",
			items_sent, acyclic_seen + cyclic_seen, acyclic_seen, cyclic_seen);
		$display("Count writes %0d; ok %0d, bad node %0d, table full %0d, out full %0d,",
			cfg_writes, status_seen[ST_OK], status_seen[ST_BAD_NODE],
			status_seen[ST_EDGES_FULL], status_seen[ST_OUT_FULL]);
		$display("in full %0d; %0d mismatches.", status_seen[ST_IN_FULL], errors);
		if (errors == 0)
			$display("[dag_edge_loader_cycle_check_core] OK");
		else
			$display("[dag_edge_loader_cycle_check_core] ERROR");
		$finish;
	end

endmodule

[dag_edge_loader_cycle_check_core.f]
rtl/dagcc_pkg.sv
rtl/dagcc_graph_store.sv
rtl/dagcc_walk_mem.sv
rtl/dag_edge_loader_cycle_check_core.sv
tb/sv/testbench.sv
